// ----- rtl/core/plwi_pkg.sv -----
// Types, widths and codes shared by the piecewise-linear weight interpolation unit.
// No dependencies; every other file of the block but plwi_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package plwi_pkg;

   // item field widths
   localparam int IDX_W  = 4;
   localparam int X_W    = 24;
   localparam int V_W    = 18;
   localparam int SH_W   = 5;
   localparam int WGT_W  = 23;
   localparam int CFG_W  = 5;

   // datapath widths
   localparam int ALU_W     = X_W + 1;
   localparam int FRAC_W    = 17;
   localparam int FRAC_SHR  = 16;
   localparam int DIFF_W    = V_W + 1;
   localparam int OPB_W     = V_W;
   localparam int PROD_W    = DIFF_W + OPB_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int DIV_STEPS = FRAC_W;
   localparam int STEP_W    = 5;

   localparam logic signed [SUM_W-1:0] WEIGHT_MAX = 38'sd4194303;
   localparam logic signed [SUM_W-1:0] WEIGHT_MIN = -38'sd4194304;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_POINTS_IN_USE = 1'b0;
   localparam logic [CFG_W-1:0] POINTS_RESET = 5'd1;

   // item codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;
   localparam logic KIND_EVAL = 1'b0;
   localparam logic KIND_ACK  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_CLAMP_RD,
      ST_CLAMP_LATCH,
      ST_LO_RD,
      ST_LO_LATCH,
      ST_HI_LATCH,
      ST_DIV,
      ST_V_SUB,
      ST_V_MUL,
      ST_E_MUL,
      ST_E_ADD,
      ST_W_MUL,
      ST_W_ADD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [X_W-1:0] x;
      logic [V_W-1:0] value;
      logic [V_W-1:0] err_up;
      logic [V_W-1:0] err_down;
   } bp_entry_type;

   typedef struct packed {
      logic                    action;
      logic [X_W-1:0]          pt;
      logic signed [SH_W-1:0]  shift;
      logic [CFG_W-1:0]        points_in_use;
   } cmd_type;

   typedef struct packed {
      logic signed [WGT_W-1:0] weight;
      logic                    clamped;
      logic                    kind;
   } res_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             ge;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/plwi_if.sv -----
// Valid/ready channel interfaces for the input and result items.
// Depends on plwi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface plwi_req_if;
   import plwi_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   action;
   logic [IDX_W-1:0]       point_index;
   logic [X_W-1:0]         point_x;
   logic [V_W-1:0]         point_value;
   logic [V_W-1:0]         point_err_up;
   logic [V_W-1:0]         point_err_down;
   logic [X_W-1:0]         pt;
   logic signed [SH_W-1:0] shift;

   modport source (
      output valid, action, point_index, point_x, point_value, point_err_up,
             point_err_down, pt, shift,
      input  ready
   );
   modport sink (
      input  valid, action, point_index, point_x, point_value, point_err_up,
             point_err_down, pt, shift,
      output ready
   );
   modport monitor (
      input valid, ready, action, point_index, point_x, point_value, point_err_up,
            point_err_down, pt, shift
   );
endinterface

interface plwi_rsp_if;
   import plwi_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [WGT_W-1:0] weight;
   logic                    clamped;
   logic                    kind;

   modport source (output valid, weight, clamped, kind, input ready);
   modport sink (input valid, weight, clamped, kind, output ready);
   modport monitor (input valid, ready, weight, clamped, kind);
endinterface

`default_nettype wire

// ----- rtl/core/plwi_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module plwi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

// ----- rtl/core/plwi_alu.sv -----
// Shared subtract/compare unit: scan compares, differences and division steps.
// Depends on plwi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plwi_alu (
   input  plwi_pkg::alu_req_type req,
   output plwi_pkg::alu_rsp_type rsp
);
   import plwi_pkg::*;

   always_comb begin
      rsp.diff = req.a - req.b;
      rsp.ge   = (req.a >= req.b);
   end
endmodule

`default_nettype wire

// ----- rtl/core/plwi_ctrl.sv -----
// Sequencer of the interpolation unit: table scan, fraction division, blends, weight.
// Depends on plwi_pkg; drives the shared plwi_alu and the breakpoint RAM read port.
`timescale 1ns / 1ps
`default_nettype none

module plwi_ctrl #(
   parameter int MAX_POINTS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  plwi_pkg::cmd_type                  cmd,
   output logic                               ready,
   output logic [$clog2(MAX_POINTS)-1:0]      raddr,
   input  plwi_pkg::bp_entry_type             rdata,
   output plwi_pkg::alu_req_type              alu_req,
   input  plwi_pkg::alu_rsp_type              alu_rsp,
   input  wire logic                          res_free,
   output logic                               res_load,
   output plwi_pkg::res_type                  res
);
   import plwi_pkg::*;

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   state_type                state_ff, state_in;
   logic [IW-1:0]            i_ff, i_in;
   logic [CW-1:0]            n_ff, n_in;
   logic [X_W-1:0]           pt_ff, pt_in;
   logic signed [SH_W-1:0]   shift_ff, shift_in;
   logic                     kind_ff, kind_in;
   logic                     clamped_ff, clamped_in;
   logic [ALU_W-1:0]         rem_ff, rem_in;
   logic [ALU_W-1:0]         den_ff, den_in;
   logic [FRAC_W-1:0]        q_ff, q_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [V_W-1:0]           vlo_ff, vlo_in, elo_ff, elo_in;
   logic [V_W-1:0]           vhi_ff, vhi_in, ehi_ff, ehi_in;
   logic signed [DIFF_W-1:0] opa_ff, opa_in;
   logic signed [OPB_W-1:0]  opb_ff, opb_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [V_W-1:0]           val_ff, val_in;
   logic signed [WGT_W-1:0]  weight_ff, weight_in;

   logic                     use_up;
   logic [V_W-1:0]           err_sel;
   logic                     last_slot;
   logic signed [DIFF_W-1:0] prod_shr;
   logic signed [DIFF_W-1:0] blend_sum;
   logic signed [SUM_W-1:0]  wsum;
   logic [ALU_W-1:0]         cand;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff       <= i_in;
      n_ff       <= n_in;
      pt_ff      <= pt_in;
      shift_ff   <= shift_in;
      kind_ff    <= kind_in;
      clamped_ff <= clamped_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      q_ff       <= q_in;
      step_ff    <= step_in;
      vlo_ff     <= vlo_in;
      elo_ff     <= elo_in;
      vhi_ff     <= vhi_in;
      ehi_ff     <= ehi_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      prod_ff    <= prod_in;
      val_ff     <= val_in;
      weight_ff  <= weight_in;
   end

   always_comb begin
      use_up    = !shift_ff[SH_W-1] && (shift_ff != '0);
      err_sel   = use_up ? rdata.err_up : rdata.err_down;
      last_slot = ((CW'(i_ff) + CW'(1)) == n_ff);
      prod_shr  = DIFF_W'(prod_ff >>> FRAC_SHR);
      blend_sum = '0;
      wsum      = SUM_W'($signed({1'b0, val_ff})) + SUM_W'(prod_ff);
      cand      = (step_ff == '0) ? rem_ff : {rem_ff[ALU_W-2:0], 1'b0};

      state_in   = state_ff;
      i_in       = i_ff;
      n_in       = n_ff;
      pt_in      = pt_ff;
      shift_in   = shift_ff;
      kind_in    = kind_ff;
      clamped_in = clamped_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      q_in       = q_ff;
      step_in    = step_ff;
      vlo_in     = vlo_ff;
      elo_in     = elo_ff;
      vhi_in     = vhi_ff;
      ehi_in     = ehi_ff;
      opa_in     = opa_ff;
      opb_in     = opb_ff;
      prod_in    = prod_ff;
      val_in     = val_ff;
      weight_in  = weight_ff;

      ready     = (state_ff == ST_IDLE);
      raddr     = i_ff;
      alu_req.a = {1'b0, rdata.x};
      alu_req.b = {1'b0, pt_ff};
      res_load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pt_in    = cmd.pt;
               shift_in = cmd.shift;
               if (cmd.points_in_use == '0) begin
                  n_in = CW'(1);
               end else if (32'(cmd.points_in_use) > MAX_POINTS) begin
                  n_in = CW'(MAX_POINTS);
               end else begin
                  n_in = CW'(cmd.points_in_use);
               end
               i_in = '0;
               if (cmd.action == ACT_LOAD) begin
                  kind_in    = KIND_ACK;
                  clamped_in = 1'b0;
                  weight_in  = '0;
                  state_in   = ST_FINISH;
               end else begin
                  kind_in  = KIND_EVAL;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            // x >= pt stops the scan; otherwise advance or run off the end
            if (!alu_rsp.ge) begin
               if (last_slot) begin
                  clamped_in = 1'b1;
                  state_in   = ST_CLAMP_RD;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_SCAN_RD;
               end
            end else if (i_ff == '0) begin
               clamped_in = 1'b1;
               state_in   = ST_CLAMP_RD;
            end else begin
               clamped_in = 1'b0;
               state_in   = ST_LO_RD;
            end
         end
         ST_CLAMP_RD: begin
            state_in = ST_CLAMP_LATCH;
         end
         ST_CLAMP_LATCH: begin
            val_in   = rdata.value;
            opa_in   = $signed({1'b0, err_sel});
            opb_in   = OPB_W'(shift_ff);
            state_in = ST_W_MUL;
         end
         ST_LO_RD: begin
            raddr    = i_ff - IW'(1);
            state_in = ST_LO_LATCH;
         end
         ST_LO_LATCH: begin
            alu_req.a = {1'b0, pt_ff};
            alu_req.b = {1'b0, rdata.x};
            rem_in    = alu_rsp.diff;
            // hold x of the low point here until the divisor is formed
            den_in    = {1'b0, rdata.x};
            vlo_in    = rdata.value;
            elo_in    = err_sel;
            state_in  = ST_HI_LATCH;
         end
         ST_HI_LATCH: begin
            alu_req.a = {1'b0, rdata.x};
            alu_req.b = den_ff;
            den_in    = alu_rsp.diff;
            vhi_in    = rdata.value;
            ehi_in    = err_sel;
            q_in      = '0;
            step_in   = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            alu_req.a = cand;
            alu_req.b = den_ff;
            q_in      = {q_ff[FRAC_W-2:0], alu_rsp.ge};
            rem_in    = alu_rsp.ge ? alu_rsp.diff : cand;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_V_SUB;
            end
         end
         ST_V_SUB: begin
            alu_req.a = {{(ALU_W-V_W){1'b0}}, vhi_ff};
            alu_req.b = {{(ALU_W-V_W){1'b0}}, vlo_ff};
            opa_in    = $signed(alu_rsp.diff[DIFF_W-1:0]);
            opb_in    = $signed({1'b0, q_ff});
            state_in  = ST_V_MUL;
         end
         ST_V_MUL: begin
            prod_in   = opa_ff * opb_ff;
            alu_req.a = {{(ALU_W-V_W){1'b0}}, ehi_ff};
            alu_req.b = {{(ALU_W-V_W){1'b0}}, elo_ff};
            opa_in    = $signed(alu_rsp.diff[DIFF_W-1:0]);
            state_in  = ST_E_MUL;
         end
         ST_E_MUL: begin
            prod_in   = opa_ff * opb_ff;
            blend_sum = $signed({1'b0, vlo_ff}) + prod_shr;
            val_in    = blend_sum[V_W-1:0];
            state_in  = ST_E_ADD;
         end
         ST_E_ADD: begin
            blend_sum = $signed({1'b0, elo_ff}) + prod_shr;
            opa_in    = blend_sum;
            opb_in    = OPB_W'(shift_ff);
            state_in  = ST_W_MUL;
         end
         ST_W_MUL: begin
            prod_in  = opa_ff * opb_ff;
            state_in = ST_W_ADD;
         end
         ST_W_ADD: begin
            if (wsum > WEIGHT_MAX) begin
               weight_in = WGT_W'(WEIGHT_MAX);
            end else if (wsum < WEIGHT_MIN) begin
               weight_in = WGT_W'(WEIGHT_MIN);
            end else begin
               weight_in = WGT_W'(wsum);
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (res_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.weight  = weight_ff;
      res.clamped = clamped_ff;
      res.kind    = kind_ff;
   end
endmodule

`default_nettype wire

// ----- rtl/core/piecewise_linear_weight_interp_unit.sv -----
// Top level of the piecewise-linear weight interpolation unit: channels, CSR, RAM.
// Depends on plwi_pkg, plwi_if, plwi_ram, plwi_alu and plwi_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// A load item writes one breakpoint into the table; its acknowledge passes through
// the finish state into the output register, after which the next item can be
// taken. An evaluate item scans the table from slot 0, with a read state and a
// compare state per slot, through the single read port of the breakpoint RAM; when
// it clamps it goes on to scale the error and form the weight, and when it
// interpolates it first divides for the fraction and forms the two blends. The
// scan and the 17-step restoring division of the fraction share one
// subtract/compare unit, and the two blends and the error scaling share one
// multiplier. The input is not ready while an item is at work; a finished result
// waits in the output register and does not hold up the next item, whose own
// result then waits until that register is free. The table holds no reset value:
// evaluate only over written slots.

module piecewise_linear_weight_interp_unit #(
   parameter int MAX_POINTS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   plwi_req_if.sink                            req_bus,
   plwi_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [plwi_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [plwi_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [plwi_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import plwi_pkg::*;

   localparam int IW = $clog2(MAX_POINTS);

   logic [CFG_W-1:0] points_ff, points_in;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_res_ff, rsp_res_in;

   logic             accept;
   logic             ram_we;
   bp_entry_type     ram_wdata, ram_rdata;
   logic [IW-1:0]    ram_raddr;
   cmd_type          cmd;
   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;
   logic             ctrl_ready, res_free, res_load;
   res_type          res;
   logic             csr_hit;

   // configuration register
   assign csr_hit    = (csr_paddr[CSR_AW-1:2] == REG_POINTS_IN_USE);
   assign csr_pready = 1'b1;

   always_comb begin
      points_in = points_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         points_in = csr_pwdata[CFG_W-1:0];
      end
      csr_prdata = csr_hit ? {{(CSR_DW-CFG_W){1'b0}}, points_ff} : '0;
   end

   // input side
   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = ctrl_ready;
   assign ram_we = accept && (req_bus.action == ACT_LOAD)
                   && (32'(req_bus.point_index) < MAX_POINTS);

   always_comb begin
      ram_wdata.x        = req_bus.point_x;
      ram_wdata.value    = req_bus.point_value;
      ram_wdata.err_up   = req_bus.point_err_up;
      ram_wdata.err_down = req_bus.point_err_down;
      cmd.action         = req_bus.action;
      cmd.pt             = req_bus.pt;
      cmd.shift          = req_bus.shift;
      cmd.points_in_use  = points_ff;
   end

   plwi_ram #(
      .WIDTH ($bits(bp_entry_type)),
      .DEPTH (MAX_POINTS)
   ) u_bp_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (IW'(req_bus.point_index)),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   plwi_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   plwi_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .cmd      (cmd),
      .ready    (ctrl_ready),
      .raddr    (ram_raddr),
      .rdata    (ram_rdata),
      .alu_req  (alu_req),
      .alu_rsp  (alu_rsp),
      .res_free (res_free),
      .res_load (res_load),
      .res      (res)
   );

   // output register
   assign res_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff    <= POINTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.weight  = rsp_res_ff.weight;
   assign rsp_bus.clamped = rsp_res_ff.clamped;
   assign rsp_bus.kind    = rsp_res_ff.kind;
endmodule

`default_nettype wire

// ----- rtl/core/plwi_checker.sv -----
// Port-level checks of the piecewise-linear weight interpolation unit, bound to the top.
// Depends on plwi_pkg and plwi_if.
`timescale 1ns / 1ps
`default_nettype none

module plwi_checker (
   input wire logic     clock,
   input wire logic     reset,
   plwi_req_if.sink     req_bus,
   plwi_rsp_if.source   rsp_bus
);
   import plwi_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid)
      else $error("result dropped while stalled");

   // a load acknowledge carries a zero weight and no clamp flag
   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.kind == KIND_ACK)
      |-> (rsp_bus.weight == '0) && !rsp_bus.clamped)
      else $error("load acknowledge with non-zero payload");

   // one item at a time: busy in the cycle after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("input ready straight after an accept");

   // reset leaves the block idle with nothing to deliver
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && req_bus.ready)
      else $error("block not idle after reset");
endmodule

bind piecewise_linear_weight_interp_unit plwi_checker u_plwi_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

`default_nettype wire
